// ----- hw/rtl/ahfb_pkg.sv -----
// Package for the ASCII hex frame builder: word and state types, control
// characters and the hex digit encoder. No dependencies.
`timescale 1ns / 1ps

package ahfb_pkg;

  localparam logic [7:0] SYM_STX    = 8'h02;
  localparam logic [7:0] SYM_ETX    = 8'h03;
  localparam logic [7:0] SYM_ERROR  = 8'h00;
  localparam logic [7:0] MIN_LENGTH = 8'd4;

  // Most words one input item can produce: STX, two length digits, the
  // payload byte, two checksum digits and ETX.
  localparam int MAX_RESULTS = 7;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic       ferr;
  } entry_t;

  typedef entry_t [MAX_RESULTS-1:0] entry_list_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    entry_list_t      list;
  } result_set_t;

  typedef struct packed {
    logic [7:0] checksum;
    logic [7:0] seen;
    logic [7:0] decl;
    logic       in_frame;
    logic       rejected;
  } frame_state_t;

  localparam entry_t ERROR_ENTRY = '{data: SYM_ERROR, fend: 1'b1, ferr: 1'b1};

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

// ----- hw/rtl/ascii_hex_frame_builder_unit.sv -----
// ASCII hex frame builder top level: input register, frame state and the
// output serializer. Uses ahfb_pkg, ahfb_frame_logic and ahfb_serializer.
// An accepted item is captured in the input register and is loaded into the
// serializer once that is free; its first word is offered from the serializer.
// Throughput: one output word per cycle while out_stall is low; an item gives
// zero to seven words, and the next item loads as the last word leaves.
// Reset (synchronous, rst_n low) empties both registers and clears the frame
// state, so the next item opens a new frame.
`timescale 1ns / 1ps

module ascii_hex_frame_builder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic [7:0] in_frame_length,
  input  logic       in_end_of_payload,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_frame_error
);

  logic                   hold_valid_r;
  logic                   hold_valid_nxt;
  logic [7:0]             hold_byte_r;
  logic [7:0]             hold_len_r;
  logic                   hold_last_r;
  ahfb_pkg::frame_state_t st_r;
  ahfb_pkg::frame_state_t st_nxt;
  ahfb_pkg::result_set_t  res;
  logic                   ser_free;
  logic                   load;
  logic                   in_take;

  assign load     = hold_valid_r && ser_free;
  assign in_stall = hold_valid_r && !ser_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_take) begin
      hold_valid_nxt = 1'b1;
    end else if (load) begin
      hold_valid_nxt = 1'b0;
    end
  end

  ahfb_frame_logic u_logic (
    .payload_byte   (hold_byte_r),
    .frame_length   (hold_len_r),
    .end_of_payload (hold_last_r),
    .st             (st_r),
    .st_nxt         (st_nxt),
    .res            (res)
  );

  ahfb_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .load_set        (res),
    .free            (ser_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end),
    .out_frame_error (out_frame_error)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      st_r         <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (load) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte_r <= in_payload_byte;
      hold_len_r  <= in_frame_length;
      hold_last_r <= in_end_of_payload;
    end
  end

endmodule

// ----- hw/rtl/ahfb_frame_logic.sv -----
// Combinational frame logic: from the current frame state and one input item,
// builds the list of output words and the next frame state. Uses ahfb_pkg.
`timescale 1ns / 1ps

module ahfb_frame_logic (
  input  logic [7:0]            payload_byte,
  input  logic [7:0]            frame_length,
  input  logic                  end_of_payload,
  input  ahfb_pkg::frame_state_t st,
  output ahfb_pkg::frame_state_t st_nxt,
  output ahfb_pkg::result_set_t  res
);

  logic       discard;
  logic       head;
  logic       short_len;
  logic       overflow;
  logic [7:0] len_hi;
  logic [7:0] len_lo;
  logic [7:0] cs_base;
  logic [7:0] cs_after;
  logic [7:0] seen_after;
  logic [7:0] decl_eff;
  logic       mismatch;
  ahfb_pkg::entry_t             tail0;
  ahfb_pkg::entry_t             tail1;
  ahfb_pkg::entry_t             tail2;
  ahfb_pkg::entry_t             pay;
  logic [ahfb_pkg::CNT_W-1:0]   tail_cnt;

  assign discard    = st.in_frame && st.rejected;
  assign head       = !st.in_frame;
  assign short_len  = head && (frame_length < ahfb_pkg::MIN_LENGTH);
  assign overflow   = st.in_frame && !st.rejected && (st.seen >= st.decl);
  assign len_hi     = ahfb_pkg::hex_digit(frame_length[7:4]);
  assign len_lo     = ahfb_pkg::hex_digit(frame_length[3:0]);
  // The length digits count toward the checksum, STX does not.
  assign cs_base    = head ? (8'h00 - len_hi - len_lo) : st.checksum;
  assign cs_after   = cs_base - payload_byte;
  assign seen_after = (head ? 8'h00 : st.seen) + 8'd1;
  assign decl_eff   = head ? frame_length : st.decl;
  assign mismatch   = seen_after != decl_eff;

  always_comb begin
    pay   = '{data: payload_byte, fend: 1'b0, ferr: 1'b0};
    tail1 = '{data: ahfb_pkg::hex_digit(cs_after[3:0]), fend: 1'b0, ferr: 1'b0};
    tail2 = '{data: ahfb_pkg::SYM_ETX, fend: 1'b1, ferr: 1'b0};
    if (mismatch) begin
      tail0    = ahfb_pkg::ERROR_ENTRY;
      tail_cnt = ahfb_pkg::CNT_W'(1);
    end else begin
      tail0    = '{data: ahfb_pkg::hex_digit(cs_after[7:4]), fend: 1'b0, ferr: 1'b0};
      tail_cnt = ahfb_pkg::CNT_W'(3);
    end
    if (!end_of_payload) begin
      tail_cnt = '0;
    end
  end

  always_comb begin
    st_nxt   = st;
    res.cnt  = '0;
    res.list = '0;
    if (discard) begin
      if (end_of_payload) begin
        st_nxt.in_frame = 1'b0;
        st_nxt.rejected = 1'b0;
      end
    end else if (short_len || overflow) begin
      res.list[0] = ahfb_pkg::ERROR_ENTRY;
      res.cnt     = ahfb_pkg::CNT_W'(1);
      if (short_len) begin
        st_nxt.decl     = frame_length;
        st_nxt.checksum = 8'h00;
        st_nxt.seen     = 8'h00;
      end
      st_nxt.in_frame = !end_of_payload;
      st_nxt.rejected = !end_of_payload;
    end else begin
      st_nxt.decl     = decl_eff;
      st_nxt.checksum = cs_after;
      st_nxt.seen     = seen_after;
      st_nxt.in_frame = !end_of_payload;
      st_nxt.rejected = 1'b0;
      if (head) begin
        res.list[0] = '{data: ahfb_pkg::SYM_STX, fend: 1'b0, ferr: 1'b0};
        res.list[1] = '{data: len_hi, fend: 1'b0, ferr: 1'b0};
        res.list[2] = '{data: len_lo, fend: 1'b0, ferr: 1'b0};
        res.list[3] = pay;
        res.list[4] = tail0;
        res.list[5] = tail1;
        res.list[6] = tail2;
        res.cnt     = ahfb_pkg::CNT_W'(4) + tail_cnt;
      end else begin
        res.list[0] = pay;
        res.list[1] = tail0;
        res.list[2] = tail1;
        res.list[3] = tail2;
        res.cnt     = ahfb_pkg::CNT_W'(1) + tail_cnt;
      end
    end
  end

endmodule

// ----- hw/rtl/ahfb_serializer.sv -----
// Output serializer: holds the words built for one item and sends them one
// per handshake, entry 0 first. Uses ahfb_pkg.
`timescale 1ns / 1ps

module ahfb_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ahfb_pkg::result_set_t load_set,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_frame_end,
  output logic                  out_frame_error
);

  ahfb_pkg::entry_list_t       list_r;
  ahfb_pkg::entry_list_t       list_nxt;
  logic [ahfb_pkg::CNT_W-1:0]  cnt_r;
  logic [ahfb_pkg::CNT_W-1:0]  cnt_nxt;
  logic                        take;

  assign out_valid       = cnt_r != '0;
  assign take            = out_valid && !out_stall;
  // Free when empty or when the last word leaves at this edge.
  assign free            = !out_valid || (take && (cnt_r == ahfb_pkg::CNT_W'(1)));
  assign out_byte        = list_r[0].data;
  assign out_frame_end   = list_r[0].fend;
  assign out_frame_error = list_r[0].ferr;

  always_comb begin
    list_nxt = list_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      list_nxt = load_set.list;
      cnt_nxt  = load_set.cnt;
    end else if (take) begin
      list_nxt = {ahfb_pkg::entry_t'('0), list_r[ahfb_pkg::MAX_RESULTS-1:1]};
      cnt_nxt  = cnt_r - ahfb_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_r <= list_nxt;
  end

endmodule

// ----- hw/rtl/ahfb_checker.sv -----
// Port-level checker for the ASCII hex frame builder, bound to the top level.
// Uses ahfb_pkg for the control characters.
`timescale 1ns / 1ps

module ahfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_payload_byte,
  input logic [7:0] in_frame_length,
  input logic       in_end_of_payload,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_frame_end,
  input logic       out_frame_error
);

  // A stalled word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_frame_end) && $stable(out_frame_error))
    else $error("stalled output word changed");

  // An error word always closes the frame and carries a zero byte.
  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |-> out_frame_end && out_byte == ahfb_pkg::SYM_ERROR)
    else $error("error word malformed");

  // A frame that closes without error closes on ETX.
  a_etx_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end && !out_frame_error |-> out_byte == ahfb_pkg::SYM_ETX)
    else $error("frame closed without ETX");

  // The input can only be held off while the output still has words to send.
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output");

  // Offered words on either channel carry known values.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid |-> !$isunknown({out_byte, out_frame_end, out_frame_error}))
      and (in_valid |-> !$isunknown({in_payload_byte, in_frame_length,
                                     in_end_of_payload})))
    else $error("unknown value on an offered word");

endmodule

bind ascii_hex_frame_builder_unit ahfb_checker u_ahfb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_payload_byte   (in_payload_byte),
  .in_frame_length   (in_frame_length),
  .in_end_of_payload (in_end_of_payload),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_frame_end     (out_frame_end),
  .out_frame_error   (out_frame_error)
);
